// File: rtl/rgbhls_pkg.sv
// Shared types, constants and divider step function for the RGB to HLS converter.
// No dependencies; used by every module under rtl.
package rgbhls_pkg;

    localparam int unsigned HLS_SCALE     = 240;
    localparam int unsigned HALF_SUM_MAX  = 256;   // lightness <= 120 exactly when max+min <= 256
    localparam int unsigned FULL_SUM      = 510;
    localparam int unsigned SECTOR_SPAN   = 40;
    localparam int unsigned GREEN_OFFSET  = 80;
    localparam int unsigned BLUE_OFFSET   = 160;
    localparam int unsigned GREY_HUE      = 160;
    localparam int unsigned SAT_QBITS     = 8;
    localparam int unsigned HUE_QBITS     = 6;
    localparam int unsigned DIV_STAGES    = SAT_QBITS;

    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } hue_sector_t;

    // Result of the first front stage
    typedef struct packed {
        logic [8:0]  sum;
        logic [7:0]  delta;
        logic [7:0]  hue_mag;
        logic        hue_neg;
        hue_sector_t sector;
    } class_t;

    // Item handed from front to back through the queue
    typedef struct packed {
        logic [7:0]  light;
        logic        grey;
        logic [15:0] sat_num;
        logic [8:0]  sat_div;
        logic [13:0] hue_num;
        logic [7:0]  hue_den;
        logic        hue_neg;
        hue_sector_t sector;
    } work_t;

    // One stage of the shared-pipeline restoring dividers
    typedef struct packed {
        logic [7:0]  light;
        logic        grey;
        logic [15:0] sat_rem;
        logic [8:0]  sat_div;
        logic [7:0]  sat_q;
        logic [13:0] hue_rem;
        logic [7:0]  hue_den;
        logic [5:0]  hue_q;
        logic        hue_neg;
        hue_sector_t sector;
    } stage_t;

    function automatic stage_t load_stage(work_t w);
        stage_t s;
        s.light   = w.light;
        s.grey    = w.grey;
        s.sat_rem = w.sat_num;
        s.sat_div = w.sat_div;
        s.sat_q   = '0;
        s.hue_rem = w.hue_num;
        s.hue_den = w.hue_den;
        s.hue_q   = '0;
        s.hue_neg = w.hue_neg;
        s.sector  = w.sector;
        return s;
    endfunction

    // One saturation bit, and a hue bit while idx < HUE_QBITS; idx counts from the top bit
    function automatic stage_t div_step(stage_t s, int unsigned idx);
        stage_t      r;
        logic [16:0] sat_sh;
        logic [16:0] sat_rem_x;
        logic [13:0] hue_sh;
        logic        sat_bit;
        logic        hue_bit;
        r         = s;
        sat_rem_x = {1'b0, s.sat_rem};
        sat_sh    = {8'd0, s.sat_div} << (SAT_QBITS - 1 - idx);
        sat_bit   = (sat_rem_x >= sat_sh);
        if (sat_bit)
        begin
            r.sat_rem = 16'(sat_rem_x - sat_sh);
        end
        r.sat_q = {s.sat_q[6:0], sat_bit};
        if (idx < HUE_QBITS)
        begin
            hue_sh  = {6'd0, s.hue_den} << (HUE_QBITS - 1 - idx);
            hue_bit = (s.hue_rem >= hue_sh);
            if (hue_bit)
            begin
                r.hue_rem = s.hue_rem - hue_sh;
            end
            r.hue_q = {s.hue_q[4:0], hue_bit};
        end
        return r;
    endfunction

    function automatic logic [8:0] sector_offset(hue_sector_t sec);
        logic [8:0] off;
        unique case (sec)
            SECTOR_GREEN: off = 9'(GREEN_OFFSET);
            SECTOR_BLUE:  off = 9'(BLUE_OFFSET);
            default:      off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

// File: rtl/rgbhls_front.sv
// Front end: accepts colour items, finds max/min, picks the hue sector and
// computes lightness and both divider operands. Uses rgbhls_pkg.
module rgbhls_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                color_valid,
    output logic                color_stall,
    input  logic [23:0]         color_word,
    output logic                work_valid,
    input  logic                work_stall,
    output rgbhls_pkg::work_t   work_data
);

    logic                 a_valid_reg;
    rgbhls_pkg::class_t   a_reg;
    rgbhls_pkg::class_t   a_next;
    logic                 b_valid_reg;
    rgbhls_pkg::work_t    b_reg;
    rgbhls_pkg::work_t    b_next;
    logic                 advance;

    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [8:0]  diff;
    logic [15:0] light_half;
    logic [15:0] light_sum;
    logic [16:0] light_num;

    assign advance     = !b_valid_reg || !work_stall;
    assign color_stall = !advance;

    // Stage A: classify
    always_comb
    begin
        red   = color_word[7:0];
        green = color_word[15:8];
        blue  = color_word[23:16];
        lo    = red;
        if (green < lo)
        begin
            lo = green;
        end
        if (blue < lo)
        begin
            lo = blue;
        end
        if (red >= green && red >= blue)
        begin
            hi            = red;
            a_next.sector = rgbhls_pkg::SECTOR_RED;
            diff          = {1'b0, green} - {1'b0, blue};
        end
        else if (green >= blue)
        begin
            hi            = green;
            a_next.sector = rgbhls_pkg::SECTOR_GREEN;
            diff          = {1'b0, blue} - {1'b0, red};
        end
        else
        begin
            hi            = blue;
            a_next.sector = rgbhls_pkg::SECTOR_BLUE;
            diff          = {1'b0, red} - {1'b0, green};
        end
        a_next.sum     = {1'b0, hi} + {1'b0, lo};
        a_next.delta   = hi - lo;
        a_next.hue_neg = diff[8];
        a_next.hue_mag = diff[8] ? 8'(-diff) : diff[7:0];
    end

    // Stage B: lightness and divider operands
    always_comb
    begin
        light_num  = 17'(a_reg.sum * 17'(rgbhls_pkg::HLS_SCALE)) + 17'd255;
        // divide by 510: halve, then divide by 255 with the 257/65536 trick
        light_half = light_num[16:1];
        light_sum  = light_half + {8'd0, light_half[15:8]} + 16'd1;

        b_next.light   = light_sum[15:8];
        b_next.grey    = (a_reg.delta == 8'd0);
        b_next.sat_num = 16'(a_reg.delta * 16'(rgbhls_pkg::HLS_SCALE));
        if (a_reg.sum <= 9'(rgbhls_pkg::HALF_SUM_MAX))
        begin
            b_next.sat_div = a_reg.sum;
        end
        else
        begin
            b_next.sat_div = 9'(rgbhls_pkg::FULL_SUM) - a_reg.sum;
        end
        if (b_next.sat_div == 9'd0)
        begin
            b_next.sat_div = 9'd1;
        end
        b_next.hue_num = 14'(a_reg.hue_mag * 14'(rgbhls_pkg::SECTOR_SPAN));
        b_next.hue_den = a_reg.delta;
        b_next.hue_neg = a_reg.hue_neg;
        b_next.sector  = a_reg.sector;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= color_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign work_valid = b_valid_reg;
    assign work_data  = b_reg;

endmodule

// File: rtl/rgbhls_queue.sv
// Short queue between front and back ends so each side stalls on its own.
// Uses rgbhls_pkg::work_t as the entry type.
module rgbhls_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_stall,
    input  rgbhls_pkg::work_t   push_data,
    output logic                head_valid,
    input  logic                head_stall,
    output rgbhls_pkg::work_t   head_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rgbhls_pkg::work_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign push_stall = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = head_valid && !head_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

    a_pop_track: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not follow a pop");

endmodule

// File: rtl/rgbhls_back.sv
// Back end: pipelined restoring dividers for saturation and hue, one quotient
// bit per stage, then hue wrap and the output register. Uses rgbhls_pkg.
module rgbhls_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    output logic                head_stall,
    input  rgbhls_pkg::work_t   head_data,
    output logic                hls_valid,
    input  logic                hls_stall,
    output logic [7:0]          hue,
    output logic [7:0]          lightness,
    output logic [7:0]          saturation
);

    localparam int unsigned NS = rgbhls_pkg::DIV_STAGES;

    logic                stage_valid_reg [NS];
    rgbhls_pkg::stage_t  stage_reg       [NS];
    logic                advance;
    logic                hls_valid_reg;
    logic [7:0]          hue_reg;
    logic [7:0]          lightness_reg;
    logic [7:0]          saturation_reg;
    logic [7:0]          hue_next;
    logic [8:0]          hue_wide;
    logic [8:0]          hue_off;
    rgbhls_pkg::stage_t  last;

    assign advance    = !hls_valid_reg || !hls_stall;
    assign head_stall = !advance;

    genvar g;
    generate
        for (g = 0; g < NS; g = g + 1)
        begin : g_stage
            if (g == 0)
            begin : g_load
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        stage_valid_reg[g] <= 1'b0;
                    end
                    else if (advance)
                    begin
                        stage_valid_reg[g] <= head_valid;
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (advance)
                    begin
                        stage_reg[g] <= rgbhls_pkg::div_step(
                            rgbhls_pkg::load_stage(head_data), g);
                    end
                end
            end
            else
            begin : g_follow
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        stage_valid_reg[g] <= 1'b0;
                    end
                    else if (advance)
                    begin
                        stage_valid_reg[g] <= stage_valid_reg[g-1];
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (advance)
                    begin
                        stage_reg[g] <= rgbhls_pkg::div_step(stage_reg[g-1], g);
                    end
                end
            end
        end
    endgenerate

    // Apply the sign after the magnitude divide, then wrap negatives
    always_comb
    begin
        last    = stage_reg[NS-1];
        hue_off = rgbhls_pkg::sector_offset(last.sector);
        if (last.hue_neg)
        begin
            hue_wide = hue_off - {3'd0, last.hue_q};
        end
        else
        begin
            hue_wide = hue_off + {3'd0, last.hue_q};
        end
        if (hue_wide[8])
        begin
            hue_wide = hue_wide + 9'(rgbhls_pkg::HLS_SCALE);
        end
        hue_next = last.grey ? 8'(rgbhls_pkg::GREY_HUE) : hue_wide[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hls_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            hls_valid_reg <= stage_valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_reg        <= hue_next;
            lightness_reg  <= last.light;
            saturation_reg <= last.grey ? 8'd0 : last.sat_q;
        end
    end

    assign hls_valid  = hls_valid_reg;
    assign hue        = hue_reg;
    assign lightness  = lightness_reg;
    assign saturation = saturation_reg;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hls_valid_reg |-> (hue_reg < 8'(rgbhls_pkg::HLS_SCALE)))
        else $error("hue outside the circle");

    a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
        hls_valid_reg |-> (lightness_reg <= 8'(rgbhls_pkg::HLS_SCALE)))
        else $error("lightness above full scale");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        hls_valid_reg |-> (saturation_reg <= 8'(rgbhls_pkg::HLS_SCALE)))
        else $error("saturation above full scale");

    a_grey_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_valid_reg[NS-1] && last.grey) |=> (saturation_reg == 8'd0))
        else $error("grey item left with saturation");

endmodule

// File: rtl/rgb_to_hls_converter.sv
// RGB to HLS converter, 0..240 integer scale.
// Input channel: color_valid / color_stall with color_word (red in bits 7:0,
// green in 15:8, blue in 23:16). An item is taken on a rising edge with
// color_valid high and color_stall low.
// Output channel: hls_valid / hls_stall with hue, lightness and saturation;
// a result is taken on a rising edge with hls_valid high and hls_stall low.
// Every item gives exactly one result, in order.
// Throughput: one item per clock while the output is not stalled.
// Path from acceptance to hls_valid: two front stages, the queue, eight
// divider stages (one quotient bit each, saturation needs eight bits) and
// the output register.
// On hls_stall with hls_valid high the back pipeline holds; the front keeps
// accepting until the QUEUE_DEPTH-item queue fills, then raises color_stall.
// Reset (rst_n low, asynchronous) empties every stage and the queue; no
// results are pending afterwards.
// Depends on rgbhls_pkg, rgbhls_front, rgbhls_queue and rgbhls_back.
module rgb_to_hls_converter
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        color_valid,
    output logic        color_stall,
    input  logic [23:0] color_word,
    output logic        hls_valid,
    input  logic        hls_stall,
    output logic [7:0]  hue,
    output logic [7:0]  lightness,
    output logic [7:0]  saturation
);

    logic               work_valid;
    logic               work_stall;
    rgbhls_pkg::work_t  work_data;
    logic               head_valid;
    logic               head_stall;
    rgbhls_pkg::work_t  head_data;

    rgbhls_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .color_valid (color_valid),
        .color_stall (color_stall),
        .color_word  (color_word),
        .work_valid  (work_valid),
        .work_stall  (work_stall),
        .work_data   (work_data)
    );

    rgbhls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (work_valid),
        .push_stall (work_stall),
        .push_data  (work_data),
        .head_valid (head_valid),
        .head_stall (head_stall),
        .head_data  (head_data)
    );

    rgbhls_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_stall (head_stall),
        .head_data  (head_data),
        .hls_valid  (hls_valid),
        .hls_stall  (hls_stall),
        .hue        (hue),
        .lightness  (lightness),
        .saturation (saturation)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_hls_converter: directed corner colours, then random
// phases with sender gaps, receiver stalls and a long output hold-off.
// Depends on rtl/rgbhls_pkg.sv and rtl/rgb_to_hls_converter.sv.
module tb;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] lightness;
        logic [7:0] saturation;
    } hls_t;

    localparam int SCALE     = 240;
    localparam int HALF      = 120;
    localparam int FULL      = 510;
    localparam int SPAN      = 40;
    localparam int GREEN_OFS = 80;
    localparam int BLUE_OFS  = 160;
    localparam int GREY_HUE  = 160;

    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 30;
    localparam int LIMIT       = 300000;

    localparam logic [7:0]  CORNER [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    localparam logic [23:0] DIRECTED [20] = '{
        24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
        24'h808080, 24'h010101, 24'h00FFFF, 24'hFFFF00, 24'hFF00FF,
        24'h4000FF, 24'hFF4000, 24'h00FF40, 24'h0101FF, 24'h0202FF,
        24'h000080, 24'h000001, 24'hFEFFFF, 24'hFFFFFE, 24'h7F8081
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        color_valid = 1'b0;
    logic        color_stall;
    logic [23:0] color_word = '0;
    logic        hls_valid;
    logic        hls_stall = 1'b0;
    logic [7:0]  hue;
    logic [7:0]  lightness;
    logic [7:0]  saturation;

    logic [23:0] colour_backlog [$];
    hls_t        expected_hls [$];
    hls_t        oldest;
    logic        took_item = 1'b0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_request = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          errors = 0;
    int          cycles = 0;

    rgb_to_hls_converter dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .color_valid (color_valid),
        .color_stall (color_stall),
        .color_word  (color_word),
        .hls_valid   (hls_valid),
        .hls_stall   (hls_stall),
        .hue         (hue),
        .lightness   (lightness),
        .saturation  (saturation)
    );

    always #5 clk = ~clk;

    function automatic hls_t rgb_to_hls(logic [23:0] colour);
        int r;
        int g;
        int b;
        int top;
        int bottom;
        int sum;
        int delta;
        int light;
        int sat;
        int h;
        int div;
        rgbhls_pkg::hue_sector_t sector;
        hls_t res;
        r = int'(colour[7:0]);
        g = int'(colour[15:8]);
        b = int'(colour[23:16]);
        // strict compares keep red ahead of green and green ahead of blue on ties
        top = r;
        sector = rgbhls_pkg::SECTOR_RED;
        if (g > top)
        begin
            top = g;
            sector = rgbhls_pkg::SECTOR_GREEN;
        end
        if (b > top)
        begin
            top = b;
            sector = rgbhls_pkg::SECTOR_BLUE;
        end
        bottom = r;
        if (g < bottom) bottom = g;
        if (b < bottom) bottom = b;
        sum = top + bottom;
        delta = top - bottom;
        light = (sum * SCALE + 255) / FULL;
        sat = 0;
        h = GREY_HUE;
        if (delta != 0)
        begin
            div = (light <= HALF) ? sum : FULL - sum;
            if (div < 1) div = 1;
            sat = (delta * SCALE) / div;
            case (sector)
                rgbhls_pkg::SECTOR_GREEN: h = GREEN_OFS + ((b - r) * SPAN) / delta;
                rgbhls_pkg::SECTOR_BLUE:  h = BLUE_OFS + ((r - g) * SPAN) / delta;
                default:                  h = ((g - b) * SPAN) / delta;
            endcase
            if (h < 0) h += SCALE;
            if (h >= SCALE) h -= SCALE;
        end
        res.hue = 8'(h);
        res.lightness = 8'(light);
        res.saturation = 8'(sat);
        return res;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Mostly random colours, with greys, tied channels and extreme channel values mixed in
    task automatic queue_colours(int count);
        logic [7:0]  v;
        logic [7:0]  w;
        logic [23:0] c;
        for (int i = 0; i < count; i++)
        begin
            v = 8'($urandom_range(255));
            w = 8'($urandom_range(255));
            case ($urandom_range(9))
                0: c = {v, v, v};
                1:
                begin
                    case ($urandom_range(2))
                        0: c = {w, v, v};
                        1: c = {v, w, v};
                        default: c = {v, v, w};
                    endcase
                end
                2: c = {CORNER[$urandom_range(5)], CORNER[$urandom_range(5)],
                        CORNER[$urandom_range(5)]};
                default: c = 24'($urandom);
            endcase
            colour_backlog.insert(colour_backlog.size(), c);
        end
    endtask

    // Hold further items back until every outstanding result is in
    task automatic drain;
        while (colour_backlog.size() != 0 || color_valid || expected_hls.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_p);
        send_idle_pct = idle_pct;
        stall_pct = stall_p;
        queue_colours(count);
        drain();
    endtask

    // Sender: advance to the next item once the current one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            color_valid <= 1'b0;
        end
        else if (!color_valid || took_item)
        begin
            if (colour_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                color_valid <= 1'b1;
                color_word <= colour_backlog.pop_front();
            end
            else
            begin
                color_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_seen != hold_request)
        begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            hls_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            hls_stall <= 1'b1;
        end
        else
        begin
            hls_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Record accepted items and check results against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_item <= color_valid && !color_stall;
            if (color_valid && !color_stall)
                expected_hls.insert(expected_hls.size(), rgb_to_hls(color_word));
            if (hls_valid && !hls_stall)
            begin
                if (expected_hls.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got hue %0d light %0d sat %0d",
                             $time, hue, lightness, saturation);
                    errors++;
                end
                else
                begin
                    oldest = expected_hls.pop_front();
                    check_field("hue", oldest.hue, hue);
                    check_field("lightness", oldest.lightness, lightness);
                    check_field("saturation", oldest.saturation, saturation);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_hls.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            colour_backlog.insert(colour_backlog.size(), DIRECTED[i]);
        drain();

        run_phase(350, 0, 0);
        run_phase(350, 77, 0);
        run_phase(350, 0, 77);
        run_phase(350, 11, 11);

        // keep offering items while the output is held so the block backs up
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = hold_request + 1;
        queue_colours(130);
        drain();

        repeat (SETTLE) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/rgbhls_pkg.sv
rtl/rgbhls_front.sv
rtl/rgbhls_queue.sv
rtl/rgbhls_back.sv
rtl/rgb_to_hls_converter.sv
sim/tb.sv
